>>> rtl/bpe_pkg.sv
// shared constants for the bilinear position embedding index and weight block
package bpe_pkg;

  localparam int POS_W  = 20;
  localparam int IDX_W  = 16;
  localparam int WGT_W  = 17;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 2;
  localparam int TAB_W  = 9;
  localparam int MRG_W  = 4;
  localparam int MM_W   = 8;

  localparam logic [CIDX_W-1:0] REG_PATCH_ROWS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_PATCH_COLS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TABLE_SIDE = 2'd2;
  localparam logic [CIDX_W-1:0] REG_MERGE_SIDE = 2'd3;

  localparam logic [CFG_W-1:0] RST_PATCH_ROWS = 11'd16;
  localparam logic [CFG_W-1:0] RST_PATCH_COLS = 11'd16;
  localparam logic [TAB_W-1:0] RST_TABLE_SIDE = 9'd48;
  localparam logic [MRG_W-1:0] RST_MERGE_SIDE = 4'd2;

endpackage

>>> rtl/bpe_div.sv
// three stage divider by multiplication with a precomputed reciprocal
module bpe_div #(
  parameter int NW = 20,
  parameter int DW = 7,
  parameter int SR = 27,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SR:0]   recip,
  input  logic [PW-1:0] pay_in,
  output logic          out_v,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [PW-1:0] pay_out
);

  logic             v1, v2;
  logic [NW-1:0]    num1, num2;
  logic [PW-1:0]    pay1, pay2;
  logic [NW+SR:0]   prod1;
  logic [NW-1:0]    q2;
  logic [NW+DW-1:0] qd2;
  logic [NW-1:0]    q0;
  logic [NW-1:0]    r_full;
  logic [DW:0]      r_t;
  logic             r_ge;

  assign q0     = prod1[SR+NW-1:SR];
  assign r_full = num2 - qd2[NW-1:0];
  assign r_t    = r_full[DW:0];
  assign r_ge   = r_t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1    <= num;
      pay1    <= pay_in;
      prod1   <= (NW+SR+1)'(num) * (NW+SR+1)'(recip);
      num2    <= num1;
      pay2    <= pay1;
      q2      <= q0;
      qd2     <= (NW+DW)'(q0) * (NW+DW)'(den);
      pay_out <= pay2;
      if (r_ge) begin
        quo <= q2 + NW'(1);
        rem <= DW'(r_t - {1'b0, den});
      end else begin
        quo <= q2;
        rem <= r_t[DW-1:0];
      end
    end
  end

endmodule

>>> rtl/bpe_cfg.sv
// configuration registers and serial precompute sequencer for block counts, reciprocals and total
module bpe_cfg #(
  parameter int MAX_SIDE = 1024,
  parameter int SW  = 11,
  parameter int SR  = 27,
  parameter int TW  = 29
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bpe_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bpe_pkg::CFG_W-1:0]  cfg_data,
  output logic [SW-1:0]             rows,
  output logic [SW-1:0]             cols,
  output logic [bpe_pkg::MRG_W-1:0] msz,
  output logic [bpe_pkg::MM_W-1:0]  mm,
  output logic [bpe_pkg::TAB_W-1:0] side,
  output logic [bpe_pkg::TAB_W-1:0] span,
  output logic [SW-1:0]             den_r,
  output logic [SW-1:0]             den_c,
  output logic [SW-1:0]             wb,
  output logic [TW-1:0]             total,
  output logic [SR:0]               rcp_mm,
  output logic [SR:0]               rcp_wb,
  output logic [SR:0]               rcp_m,
  output logic [SR:0]               rcp_r,
  output logic [SR:0]               rcp_c,
  output logic                      busy
);

  localparam int DVW = (SW > bpe_pkg::MM_W) ? SW : bpe_pkg::MM_W;
  localparam int CW  = $clog2(SR + 2);

  localparam logic [3:0] ST_HB   = 4'd0;
  localparam logic [3:0] ST_WB   = 4'd1;
  localparam logic [3:0] ST_RMM  = 4'd2;
  localparam logic [3:0] ST_RWB  = 4'd3;
  localparam logic [3:0] ST_RM   = 4'd4;
  localparam logic [3:0] ST_RR   = 4'd5;
  localparam logic [3:0] ST_RC   = 4'd6;
  localparam logic [3:0] ST_MUL1 = 4'd7;
  localparam logic [3:0] ST_MUL2 = 4'd8;

  logic [bpe_pkg::CFG_W-1:0] rows_reg, cols_reg;
  logic [bpe_pkg::TAB_W-1:0] side_reg;
  logic [bpe_pkg::MRG_W-1:0] msz_reg;

  logic [3:0]     step;
  logic           ld;
  logic [CW-1:0]  cnt;
  logic [SR:0]    dvd, dvd_next, dividend, q_res;
  logic [DVW-1:0] dvs, rem, rem_next;
  logic [DVW:0]   t;
  logic           ge;
  logic [SW-1:0]  hb;
  logic [2*SW-1:0] hw;

  assign rows  = (32'(rows_reg) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(rows_reg);
  assign cols  = (32'(cols_reg) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cols_reg);
  assign msz   = (msz_reg == '0) ? bpe_pkg::MRG_W'(1) : msz_reg;
  assign mm    = bpe_pkg::MM_W'(bpe_pkg::MM_W'(msz) * bpe_pkg::MM_W'(msz));
  assign side  = (side_reg == '0) ? bpe_pkg::TAB_W'(1) : side_reg;
  assign span  = side - bpe_pkg::TAB_W'(1);
  assign den_r = rows - SW'(1);
  assign den_c = cols - SW'(1);

  always_comb begin
    dividend = {1'b1, {SR{1'b0}}};
    dvs      = '0;
    case (step)
      ST_HB: begin
        dividend = (SR+1)'(rows);
        dvs      = DVW'(msz);
      end
      ST_WB: begin
        dividend = (SR+1)'(cols);
        dvs      = DVW'(msz);
      end
      ST_RMM: dvs = DVW'(mm);
      ST_RWB: dvs = DVW'(wb);
      ST_RM:  dvs = DVW'(msz);
      ST_RR:  dvs = (rows <= SW'(1)) ? '0 : DVW'(den_r);
      ST_RC:  dvs = (cols <= SW'(1)) ? '0 : DVW'(den_c);
      default: dvs = '0;
    endcase
  end

  assign t        = {rem, dvd[SR]};
  assign ge       = t >= {1'b0, dvs};
  assign rem_next = ge ? DVW'(t - {1'b0, dvs}) : t[DVW-1:0];
  assign dvd_next = {dvd[SR-1:0], ge};
  assign q_res    = (dvs == '0) ? '0 : dvd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= bpe_pkg::RST_PATCH_ROWS;
      cols_reg <= bpe_pkg::RST_PATCH_COLS;
      side_reg <= bpe_pkg::RST_TABLE_SIDE;
      msz_reg  <= bpe_pkg::RST_MERGE_SIDE;
      busy     <= 1'b1;
      step     <= ST_HB;
      ld       <= 1'b1;
      cnt      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpe_pkg::REG_PATCH_ROWS: rows_reg <= cfg_data;
        bpe_pkg::REG_PATCH_COLS: cols_reg <= cfg_data;
        bpe_pkg::REG_TABLE_SIDE: side_reg <= cfg_data[bpe_pkg::TAB_W-1:0];
        bpe_pkg::REG_MERGE_SIDE: msz_reg  <= cfg_data[bpe_pkg::MRG_W-1:0];
        default: ;
      endcase
      busy <= 1'b1;
      step <= ST_HB;
      ld   <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (step == ST_MUL1) begin
        step <= ST_MUL2;
      end else if (step == ST_MUL2) begin
        busy <= 1'b0;
      end else if (ld) begin
        ld  <= 1'b0;
        cnt <= '0;
      end else if (cnt == CW'(SR)) begin
        ld   <= 1'b1;
        step <= step + 4'd1;
      end else begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && ld) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
    if (busy && step == ST_MUL1) hw <= (2*SW)'(hb) * (2*SW)'(wb);
    if (busy && step == ST_MUL2) total <= TW'(hw) * TW'(mm);
    if (busy && !ld && cnt == CW'(SR)) begin
      case (step)
        ST_HB:  hb     <= SW'(q_res);
        ST_WB:  wb     <= SW'(q_res);
        ST_RMM: rcp_mm <= q_res;
        ST_RWB: rcp_wb <= q_res;
        ST_RM:  rcp_m  <= q_res;
        ST_RR:  rcp_r  <= q_res;
        ST_RC:  rcp_c  <= q_res;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/bilinear_pos_embed_index_weight.sv
// top level: position decode, align-corners mapping, neighbour indices and weights
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall   | out_position
//  output  | out       | out_valid/out_stall | four indices, four weights, valid_res
//  config  | in        | cfg_we              | cfg_index, cfg_data
//
// one position per cycle while in_stall is low; each result passes through
// 16 register stages, with four reciprocal dividers in a chain
// after reset or any config write, in_stall stays high while the block counts,
// reciprocals and total are recomputed
// out_stall while out_valid is high freezes the whole pipeline; nothing is dropped or repeated
module bilinear_pos_embed_index_weight #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_SIDE  = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bpe_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bpe_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bpe_pkg::POS_W-1:0]   out_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bpe_pkg::IDX_W-1:0]   index_top_left,
  output logic [bpe_pkg::IDX_W-1:0]   index_top_right,
  output logic [bpe_pkg::IDX_W-1:0]   index_bottom_left,
  output logic [bpe_pkg::IDX_W-1:0]   index_bottom_right,
  output logic [bpe_pkg::WGT_W-1:0]   weight_top_left,
  output logic [bpe_pkg::WGT_W-1:0]   weight_top_right,
  output logic [bpe_pkg::WGT_W-1:0]   weight_bottom_left,
  output logic [bpe_pkg::WGT_W-1:0]   weight_bottom_right,
  output logic                        valid_res
);

  localparam int FB  = FRAC_BITS;
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int KW  = bpe_pkg::POS_W;
  localparam int TB  = bpe_pkg::TAB_W;
  localparam int NW  = SW + TB;
  localparam int FW  = SW + FB;
  localparam int SR0 = (FW > KW) ? FW : KW;
  localparam int SR  = (NW > SR0) ? NW : SR0;
  localparam int TW  = 2 * SW + bpe_pkg::MM_W;
  localparam int MW  = bpe_pkg::MM_W;
  localparam int PW2 = 2 * FB + 2;

  logic [SW-1:0] rows, cols, den_r, den_c, wb;
  logic [bpe_pkg::MRG_W-1:0] msz;
  logic [MW-1:0] mm;
  logic [TB-1:0] side, span;
  logic [TW-1:0] total;
  logic [SR:0]   rcp_mm, rcp_wb, rcp_m, rcp_r, rcp_c;
  logic          busy;

  logic en, accept, ok0;

  bpe_cfg #(.MAX_SIDE(MAX_SIDE), .SW(SW), .SR(SR), .TW(TW)) u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .rows, .cols, .msz, .mm, .side, .span, .den_r, .den_c, .wb, .total,
    .rcp_mm, .rcp_wb, .rcp_m, .rcp_r, .rcp_c, .busy
  );

  assign en       = !(out_valid && out_stall);
  assign in_stall = busy || !en;
  assign accept   = in_valid && !in_stall;
  assign ok0      = (TW+KW)'(out_position) < (TW+KW)'(total);

  // block number and offset inside the block
  logic          v1;
  logic [KW-1:0] blk;
  logic [MW-1:0] roff;
  logic [0:0]    ok1;

  bpe_div #(.NW(KW), .DW(MW), .SR(SR), .PW(1)) u_div_blk (
    .clk, .rst, .en, .in_v(accept), .num(out_position), .den(mm), .recip(rcp_mm),
    .pay_in(ok0), .out_v(v1), .quo(blk), .rem(roff), .pay_out(ok1)
  );

  // block row/column and in-block row/column
  logic                     v2a, v2b;
  logic [KW-1:0]            bq;
  logic [SW-1:0]            bc;
  logic [MW-1:0]            rq;
  logic [bpe_pkg::MRG_W-1:0] rr;
  logic [0:0]               ok2a, ok2b;

  bpe_div #(.NW(KW), .DW(SW), .SR(SR), .PW(1)) u_div_bw (
    .clk, .rst, .en, .in_v(v1), .num(blk), .den(wb), .recip(rcp_wb),
    .pay_in(ok1), .out_v(v2a), .quo(bq), .rem(bc), .pay_out(ok2a)
  );

  bpe_div #(.NW(MW), .DW(bpe_pkg::MRG_W), .SR(SR), .PW(1)) u_div_m (
    .clk, .rst, .en, .in_v(v1), .num(roff), .den(msz), .recip(rcp_m),
    .pay_in(ok1), .out_v(v2b), .quo(rq), .rem(rr), .pay_out(ok2b)
  );

  // patch row and column, then scaled numerators
  logic          v3, v4, ok3, ok4;
  logic [SW-1:0] row, col;
  logic [NW-1:0] numr, numc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v3 <= v2a && v2b;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok3  <= ok2a[0] && ok2b[0];
      row  <= SW'((SW+4)'(bq[SW-1:0]) * (SW+4)'(msz) + (SW+4)'(rq));
      col  <= SW'((SW+4)'(bc) * (SW+4)'(msz) + (SW+4)'(rr));
      ok4  <= ok3;
      numr <= NW'(row) * NW'(span);
      numc <= NW'(col) * NW'(span);
    end
  end

  // floor positions on the table grid
  logic          v5r, v5c;
  logic [NW-1:0] hq, wq;
  logic [SW-1:0] hrem, wrem;
  logic [0:0]    ok5r, ok5c;

  bpe_div #(.NW(NW), .DW(SW), .SR(SR), .PW(1)) u_div_hf (
    .clk, .rst, .en, .in_v(v4), .num(numr), .den(den_r), .recip(rcp_r),
    .pay_in(ok4), .out_v(v5r), .quo(hq), .rem(hrem), .pay_out(ok5r)
  );

  bpe_div #(.NW(NW), .DW(SW), .SR(SR), .PW(1)) u_div_wf (
    .clk, .rst, .en, .in_v(v4), .num(numc), .den(den_c), .recip(rcp_c),
    .pay_in(ok4), .out_v(v5c), .quo(wq), .rem(wrem), .pay_out(ok5c)
  );

  // fractions
  logic          v6r, v6c;
  logic [FW-1:0] dhq, dwq;
  logic [SW-1:0] unused_r, unused_c;
  logic [TB:0]   p6r, p6c;

  bpe_div #(.NW(FW), .DW(SW), .SR(SR), .PW(TB+1)) u_div_dh (
    .clk, .rst, .en, .in_v(v5r), .num({hrem, {FB{1'b0}}}), .den(den_r), .recip(rcp_r),
    .pay_in({ok5r[0], hq[TB-1:0]}), .out_v(v6r), .quo(dhq), .rem(unused_r), .pay_out(p6r)
  );

  bpe_div #(.NW(FW), .DW(SW), .SR(SR), .PW(TB+1)) u_div_dw (
    .clk, .rst, .en, .in_v(v5c), .num({wrem, {FB{1'b0}}}), .den(den_c), .recip(rcp_c),
    .pay_in({ok5c[0], wq[TB-1:0]}), .out_v(v6c), .quo(dwq), .rem(unused_c), .pay_out(p6c)
  );

  // neighbours, row offsets and complementary fractions
  logic          v7, ok7;
  logic [TB-1:0] hf, wf, hc, wc, wf7, wc7;
  logic [FB-1:0] dh, dw;
  logic [FB:0]   dh7, dw7, odh7, odw7;
  logic [2*TB-1:0] ihf7, ihc7;

  assign hf = (rows <= SW'(1)) ? '0 : p6r[TB-1:0];
  assign wf = (cols <= SW'(1)) ? '0 : p6c[TB-1:0];
  assign dh = (rows <= SW'(1) || unused_r == SW'(0) && 1'b0) ? '0 : dhq[FB-1:0];
  assign dw = (cols <= SW'(1)) ? '0 : dwq[FB-1:0];
  assign hc = ((TB+1)'(hf) + (TB+1)'(1) > (TB+1)'(span)) ? span : hf + TB'(1);
  assign wc = ((TB+1)'(wf) + (TB+1)'(1) > (TB+1)'(span)) ? span : wf + TB'(1);

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6r && v6c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok7  <= p6r[TB] && p6c[TB] && (unused_c == unused_c);
      wf7  <= wf;
      wc7  <= wc;
      ihf7 <= (2*TB)'(hf) * (2*TB)'(side);
      ihc7 <= (2*TB)'(hc) * (2*TB)'(side);
      dh7  <= (FB+1)'(dh);
      dw7  <= (FB+1)'(dw);
      odh7 <= {1'b1, {FB{1'b0}}} - (FB+1)'(dh);
      odw7 <= {1'b1, {FB{1'b0}}} - (FB+1)'(dw);
    end
  end

  // output register
  logic [PW2-1:0] p_tl, p_tr, p_bl, p_br;

  assign p_tl = PW2'(odh7) * PW2'(odw7);
  assign p_tr = PW2'(odh7) * PW2'(dw7);
  assign p_bl = PW2'(dh7) * PW2'(odw7);
  assign p_br = PW2'(dh7) * PW2'(dw7);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      valid_res <= ok7;
      if (ok7) begin
        index_top_left      <= bpe_pkg::IDX_W'(ihf7 + (2*TB)'(wf7));
        index_top_right     <= bpe_pkg::IDX_W'(ihf7 + (2*TB)'(wc7));
        index_bottom_left   <= bpe_pkg::IDX_W'(ihc7 + (2*TB)'(wf7));
        index_bottom_right  <= bpe_pkg::IDX_W'(ihc7 + (2*TB)'(wc7));
        weight_top_left     <= bpe_pkg::WGT_W'(p_tl >> FB);
        weight_top_right    <= bpe_pkg::WGT_W'(p_tr >> FB);
        weight_bottom_left  <= bpe_pkg::WGT_W'(p_bl >> FB);
        weight_bottom_right <= bpe_pkg::WGT_W'(p_br >> FB);
      end else begin
        index_top_left      <= '0;
        index_top_right     <= '0;
        index_bottom_left   <= '0;
        index_bottom_right  <= '0;
        weight_top_left     <= '0;
        weight_top_right    <= '0;
        weight_bottom_left  <= '0;
        weight_bottom_right <= '0;
      end
    end
  end

endmodule

>>> rtl/bpe_checker.sv
// port-level checker for the position embedding index and weight block, with bind
module bpe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bpe_pkg::IDX_W-1:0]   index_top_left,
  input logic [bpe_pkg::IDX_W-1:0]   index_bottom_right,
  input logic [bpe_pkg::WGT_W-1:0]   weight_top_left,
  input logic [bpe_pkg::WGT_W-1:0]   weight_top_right,
  input logic [bpe_pkg::WGT_W-1:0]   weight_bottom_left,
  input logic [bpe_pkg::WGT_W-1:0]   weight_bottom_right,
  input logic                        valid_res
);

  logic [bpe_pkg::WGT_W+1:0] wsum;

  assign wsum = (bpe_pkg::WGT_W+2)'(weight_top_left) + (bpe_pkg::WGT_W+2)'(weight_top_right)
              + (bpe_pkg::WGT_W+2)'(weight_bottom_left)
              + (bpe_pkg::WGT_W+2)'(weight_bottom_right);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(index_top_left) && $stable(weight_top_left))
    else $error("stalled output transaction changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> index_top_left == '0 && index_bottom_right == '0
      && wsum == '0)
    else $error("out of range transaction carries nonzero fields");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> wsum <= (bpe_pkg::WGT_W+2)'(65536))
    else $error("weights sum above one");

  a_stall_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input accepted during precompute after reset");

endmodule

bind bilinear_pos_embed_index_weight bpe_checker u_bpe_checker (.*);
